// ===== rtl/rhsv_pkg.sv =====
// Shared types, constants and the divider step for the RGB to HSV pipeline.
package rhsv_pkg;

  // Channel width and the widths of the divider lanes.
  localparam int unsigned CH_W   = 8;
  localparam int unsigned DIV_QW = 9;            // quotient bits, one per stage
  localparam int unsigned DIV_NW = CH_W + DIV_QW; // numerator width
  localparam int unsigned DEG_W  = 9;            // hue in degrees, 0..359

  localparam logic [DIV_NW-1:0] DEG_SECTOR = DIV_NW'(60);
  localparam logic [DIV_NW-1:0] DEG_GREEN  = DIV_NW'(120);
  localparam logic [DIV_NW-1:0] DEG_BLUE   = DIV_NW'(240);
  localparam logic [DEG_W-1:0]  DEG_FULL   = DEG_W'(360);

  // One stage of both restoring dividers plus sideband.
  typedef struct packed {
    logic [CH_W-1:0]   h_rem;
    logic [DIV_QW-1:0] h_num;   // numerator bits still to bring down
    logic [DIV_QW-1:0] h_quo;
    logic [CH_W-1:0]   h_den;   // delta
    logic [CH_W-1:0]   s_rem;
    logic [DIV_QW-1:0] s_num;
    logic [DIV_QW-1:0] s_quo;
    logic [CH_W-1:0]   s_den;   // max
    logic [CH_W-1:0]   bright;
    logic              red_neg; // red max with green below blue
    logic              hue_zero;
    logic              sat_zero;
  } div_t;

  typedef struct packed {
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] sat;
    logic [CH_W-1:0] bright;
  } hsv_t;

  // Bring down one numerator bit in each lane and do one compare/subtract.
  function automatic div_t div_step(div_t s);
    div_t             n;
    logic [CH_W:0]    th;
    logic [CH_W:0]    ts;
    n  = s;
    th = {s.h_rem, s.h_num[DIV_QW-1]};
    ts = {s.s_rem, s.s_num[DIV_QW-1]};
    if (th >= {1'b0, s.h_den}) begin
      n.h_rem = CH_W'(th - {1'b0, s.h_den});
      n.h_quo = {s.h_quo[DIV_QW-2:0], 1'b1};
    end else begin
      n.h_rem = th[CH_W-1:0];
      n.h_quo = {s.h_quo[DIV_QW-2:0], 1'b0};
    end
    if (ts >= {1'b0, s.s_den}) begin
      n.s_rem = CH_W'(ts - {1'b0, s.s_den});
      n.s_quo = {s.s_quo[DIV_QW-2:0], 1'b1};
    end else begin
      n.s_rem = ts[CH_W-1:0];
      n.s_quo = {s.s_quo[DIV_QW-2:0], 1'b0};
    end
    n.h_num = {s.h_num[DIV_QW-2:0], 1'b0};
    n.s_num = {s.s_num[DIV_QW-2:0], 1'b0};
    return n;
  endfunction

endpackage

// ===== rtl/rhsv_if.sv =====
// Stream interfaces for RGB pixels in and HSV pixels out.
interface rhsv_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhsv_hsv_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// ===== rtl/rhsv_front.sv =====
// Front stage: max/min/delta, hue sector and the two divider numerators.
module rhsv_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               red_i,
  input  logic [7:0]               green_i,
  input  logic [7:0]               blue_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output rhsv_pkg::div_t           out_data_o
);
  import rhsv_pkg::*;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  logic [CH_W-1:0]   mx, mn, delta, diff;
  logic [DIV_NW-1:0] hnum;
  logic [15:0]       snum;
  logic              neg;
  sector_e           sec;
  div_t              st_d, st_q;
  logic              valid_q;
  logic              ce;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;
    delta = mx - mn;

    // ties: red first, then green
    priority if (red_i >= green_i && red_i >= blue_i) sec = SEC_RED;
    else if (green_i >= blue_i)                       sec = SEC_GREEN;
    else                                              sec = SEC_BLUE;

    neg  = 1'b0;
    diff = '0;
    unique case (sec)
      SEC_RED: begin
        neg  = (green_i < blue_i);
        diff = neg ? (blue_i - green_i) : (green_i - blue_i);
        hnum = DIV_NW'(diff) * DEG_SECTOR;
      end
      SEC_GREEN: begin
        hnum = DIV_NW'(blue_i) * DEG_SECTOR + DIV_NW'(delta) * DEG_GREEN
             - DIV_NW'(red_i) * DEG_SECTOR;
      end
      SEC_BLUE: begin
        hnum = DIV_NW'(red_i) * DEG_SECTOR + DIV_NW'(delta) * DEG_BLUE
             - DIV_NW'(green_i) * DEG_SECTOR;
      end
      default: hnum = '0;
    endcase

    snum = 16'(delta) * 16'(255);

    // quotient fits DIV_QW bits, so the top numerator bits start as remainder
    st_d.h_rem    = hnum[DIV_NW-1:DIV_QW];
    st_d.h_num    = hnum[DIV_QW-1:0];
    st_d.h_quo    = '0;
    st_d.h_den    = delta;
    st_d.s_rem    = {1'b0, snum[15:DIV_QW]};
    st_d.s_num    = snum[DIV_QW-1:0];
    st_d.s_quo    = '0;
    st_d.s_den    = mx;
    st_d.bright   = mx;
    st_d.red_neg  = neg;
    st_d.hue_zero = (delta == '0);
    st_d.sat_zero = (mx == '0);
  end

  assign ce = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ce) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      st_q <= st_d;
    end
  end

  assign in_ready_o  = ce;
  assign out_valid_o = valid_q;
  assign out_data_o  = st_q;
endmodule

// ===== rtl/rhsv_div_pipe.sv =====
// Pipelined restoring dividers for hue and saturation, one quotient bit per stage.
module rhsv_div_pipe (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rhsv_pkg::div_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rhsv_pkg::div_t out_data_o
);
  import rhsv_pkg::*;

  logic [DIV_QW-1:0] valid_q;
  div_t              st_q [DIV_QW];
  logic [DIV_QW:0]   ce;

  assign ce[DIV_QW] = out_ready_i;

  for (genvar k = 0; k < DIV_QW; k++) begin : g_stage
    // a stage moves when empty or when the next one moves
    assign ce[k] = !valid_q[k] || ce[k+1];

    if (k == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[k] <= 1'b0;
        end else if (ce[k]) begin
          valid_q[k] <= in_valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (ce[k]) begin
          st_q[k] <= div_step(in_data_i);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[k] <= 1'b0;
        end else if (ce[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (ce[k]) begin
          st_q[k] <= div_step(st_q[k-1]);
        end
      end
    end
  end

  assign in_ready_o  = ce[0];
  assign out_valid_o = valid_q[DIV_QW-1];
  assign out_data_o  = st_q[DIV_QW-1];
endmodule

// ===== rtl/rhsv_back.sv =====
// Back end: hue fixup, degree to byte scaling and the output register.
module rhsv_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rhsv_pkg::div_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rhsv_pkg::hsv_t out_data_o
);
  import rhsv_pkg::*;

  logic [DEG_W-1:0] hdeg;
  logic [12:0]      x17;
  logic [9:0]       y_d, y_q;
  logic [CH_W-1:0]  sat_d, sat_q, bright_q;
  logic [18:0]      prod;
  hsv_t             out_d, out_q;
  logic             va_q, vb_q;
  logic             ce_a, ce_b;

  // hdeg * 255 / 360 = (hdeg * 17 / 8) / 3; y / 3 = (y * 683) >> 11 for y < 2048
  always_comb begin
    if (in_data_i.hue_zero) begin
      hdeg = '0;
    end else if (in_data_i.red_neg && in_data_i.h_quo != '0) begin
      hdeg = DEG_FULL - in_data_i.h_quo;
    end else begin
      hdeg = in_data_i.h_quo;
    end
    x17   = 13'(hdeg) * 13'(17);
    y_d   = x17[12:3];
    sat_d = in_data_i.sat_zero ? '0 : in_data_i.s_quo[CH_W-1:0];
  end

  always_comb begin
    prod          = 19'(y_q) * 19'(683);
    out_d.hue     = prod[18:11];
    out_d.sat     = sat_q;
    out_d.bright  = bright_q;
  end

  assign ce_b = !vb_q || out_ready_i;
  assign ce_a = !va_q || ce_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ce_a) va_q <= in_valid_i;
      if (ce_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_a) begin
      y_q      <= y_d;
      sat_q    <= sat_d;
      bright_q <= in_data_i.bright;
    end
    if (ce_b) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = ce_a;
  assign out_valid_o = vb_q;
  assign out_data_o  = out_q;
endmodule

// ===== rtl/rgb_to_hsv_8bit.sv =====
// RGB to HSV pixel converter, 8 bits per channel: one item per cycle while the output is not stalled.
// The pipeline has 1 front stage, 9 divider stages (one quotient bit each) and 2 back stages.
// One item per clock unless the output stalls, set by the per-bit stages of the two dividers.
// Each stage advances when it is empty or its successor advances, so bubbles
// close up and, until every stage is full, new items are taken while the output waits.
// Reset clears only the stage valid bits; payload registers are not reset.
module rgb_to_hsv_8bit (
  input  logic       clk_i,
  input  logic       rst_ni,
  rhsv_pix_if.sink   pix_i,
  rhsv_hsv_if.source hsv_o
);
  import rhsv_pkg::*;

  // front -> divider
  logic fd_valid, fd_ready;
  div_t fd_data;
  // divider -> back end
  logic db_valid, db_ready;
  div_t db_data;
  // back end -> port
  hsv_t res;

  // Front: max/min/delta, pick the hue sector (red wins ties, then green) and
  // form both numerators so that each quotient fits nine bits.
  rhsv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .red_i       (pix_i.red),
    .green_i     (pix_i.green),
    .blue_i      (pix_i.blue),
    .out_valid_o (fd_valid),
    .out_ready_i (fd_ready),
    .out_data_o  (fd_data)
  );

  // Hue numerator / delta and 255*delta / max, side by side.
  rhsv_div_pipe u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fd_valid),
    .in_ready_o  (fd_ready),
    .in_data_i   (fd_data),
    .out_valid_o (db_valid),
    .out_ready_i (db_ready),
    .out_data_o  (db_data)
  );

  // Wrap negative red-sector hues, then scale degrees by 255/360.
  rhsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (db_valid),
    .in_ready_o  (db_ready),
    .in_data_i   (db_data),
    .out_valid_o (hsv_o.valid),
    .out_ready_i (hsv_o.ready),
    .out_data_o  (res)
  );

  assign hsv_o.hue        = res.hue;
  assign hsv_o.saturation = res.sat;
  assign hsv_o.brightness = res.bright;

`ifndef SYNTH
  // A black pixel has no saturation and no hue.
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid && hsv_o.brightness == 8'd0 |-> hsv_o.saturation == 8'd0 && hsv_o.hue == 8'd0)
    else $error("black pixel with nonzero hue or saturation");

  // Zero saturation means a gray pixel, whose hue is zero.
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid && hsv_o.saturation == 8'd0 |-> hsv_o.hue == 8'd0)
    else $error("gray pixel with nonzero hue");

  // Input is only held off while a result waits at the output.
  a_nostall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> hsv_o.valid && !hsv_o.ready)
    else $error("input stalled with output free");
`endif
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the 8-bit RGB to HSV pixel converter.
module tb_top;
  import rhsv_pkg::*;

  // Pipeline depth of the block; used for the tail wait only.
  localparam int LATENCY     = 12;
  // Cycles with no item moved on either side before the run is called hung.
  localparam int STALL_LIMIT = 2000;

  // Values that sit on the edges of the channel range.
  localparam logic [7:0] EXTREME_VALS [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};

  // Hand-picked pixels, written as red/green/blue bytes.
  localparam logic [23:0] CORNER_PIX [24] = '{
    24'h000000,  // black: max is zero, so no saturation and no hue
    24'hFFFFFF,  // white: gray, delta zero
    24'h808080,  // mid gray
    24'h010101,  // dim gray
    24'hFF0000,  // pure red
    24'h00FF00,  // pure green
    24'h0000FF,  // pure blue
    24'hFFFF00,  // red and green tie, red wins
    24'h00FFFF,  // green and blue tie, green wins
    24'hFF00FF,  // red and blue tie, red wins
    24'hFF0001,  // red max with green below blue: the quotient truncates to zero, so no wrap
    24'hFF0100,
    24'h010000,  // smallest nonzero max, one channel at a time
    24'h000100,
    24'h000001,
    24'hC86496,  // red max, negative sector offset
    24'hFF8040,
    24'h40FF80,
    24'h7F40FF,
    24'hFFFE00,
    24'h0AFFFE,
    24'hFE00FF,
    24'h010203,
    24'hFF00FE
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  rhsv_pix_if pix ();
  rhsv_hsv_if hsv ();

  // Driver-owned copies of the block inputs, known from time zero.
  logic       tx_valid = 1'b0;
  logic [7:0] tx_red   = 8'd0;
  logic [7:0] tx_green = 8'd0;
  logic [7:0] tx_blue  = 8'd0;
  logic       rx_ready = 1'b0;

  assign pix.valid = tx_valid;
  assign pix.red   = tx_red;
  assign pix.green = tx_green;
  assign pix.blue  = tx_blue;
  assign hsv.ready = rx_ready;

  rgb_to_hsv_8bit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix),
    .hsv_o  (hsv)
  );

  rgb_t pixel_q[$];      // pixels waiting to be sent
  hsv_t hsv_expect_q[$]; // predicted HSV, oldest first
  rgb_t tx_next;

  bit tx_hold     = 1'b1; // sender pause, released by the phase sequencer
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  bit pix_took;
  bit hsv_took;
  int stall_cycles = 0;
  int err_cnt      = 0;

  // Integer HSV: hue in whole degrees first, then scaled to a byte.
  // All divisions truncate toward zero, as the hardware dividers do.
  function automatic hsv_t hsv_predict(input rgb_t px);
    int   r, g, b;
    int   top, bot, span, deg;
    hsv_t res;
    r   = px.red;
    g   = px.green;
    b   = px.blue;
    top = r;
    bot = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < bot) bot = g;
    if (b < bot) bot = b;
    span = top - bot;
    // Ties resolve red, then green, then blue.
    if (span == 0) begin
      deg = 0;
    end else if (top == r) begin
      deg = (60 * (g - b)) / span;
      if (deg < 0) deg += 360;
    end else if (top == g) begin
      deg = (60 * (b - r) + 120 * span) / span;
    end else begin
      deg = (60 * (r - g) + 240 * span) / span;
    end
    res.hue    = 8'((deg * 255) / 360);
    res.sat    = (top == 0) ? 8'd0 : 8'((255 * span) / top);
    res.bright = 8'(top);
    return res;
  endfunction

  // Random pixel: six in ten uniform, the rest aimed at grays, ties, range edges
  // and tiny values where the dividers see their smallest operands.
  function automatic rgb_t rand_pixel();
    rgb_t       px;
    logic [7:0] base;
    logic [7:0] other;
    base  = 8'($urandom_range(255));
    other = 8'($urandom_range(255));
    case ($urandom_range(9))
      5: begin
        // near gray: a shared base with the low bits jittered
        px.red   = base ^ 8'($urandom_range(3));
        px.green = base ^ 8'($urandom_range(3));
        px.blue  = base ^ 8'($urandom_range(3));
      end
      6: begin
        // two channels equal, picked at random
        case ($urandom_range(2))
          0:       px = '{base, base, other};
          1:       px = '{other, base, base};
          default: px = '{base, other, base};
        endcase
      end
      7: begin
        px.red   = EXTREME_VALS[$urandom_range(5)];
        px.green = EXTREME_VALS[$urandom_range(5)];
        px.blue  = EXTREME_VALS[$urandom_range(5)];
      end
      8: begin
        px.red   = 8'($urandom_range(7));
        px.green = 8'($urandom_range(7));
        px.blue  = 8'($urandom_range(7));
      end
      default: begin
        px.red   = base;
        px.green = other;
        px.blue  = 8'($urandom_range(255));
      end
    endcase
    return px;
  endfunction

  task automatic check_field(input string nm, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, want, got);
      err_cnt++;
    end
  endtask

  // Driver: new values only on the falling edge. An item stays on the bus
  // until the rising edge that accepts it.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!tx_valid || pix_took) begin
        if (!tx_hold && pixel_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          tx_next = pixel_q.pop_front();
          tx_valid <= 1'b1;
          tx_red   <= tx_next.red;
          tx_green <= tx_next.green;
          tx_blue  <= tx_next.blue;
        end else begin
          tx_valid <= 1'b0;
        end
      end
      rx_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: both handshakes sampled on the rising edge. Accepted pixels are
  // predicted right away; accepted results are checked in order.
  always @(posedge clk) begin
    pix_took = rst_n && pix.valid && pix.ready;
    hsv_took = rst_n && hsv.valid && hsv.ready;
    if (pix_took) begin
      hsv_expect_q.push_back(hsv_predict('{pix.red, pix.green, pix.blue}));
    end
    if (hsv_took) begin
      if (hsv_expect_q.size() == 0) begin
        $display("%0t: unexpected result, got hue %0d sat %0d bright %0d",
                 $time, hsv.hue, hsv.saturation, hsv.brightness);
        err_cnt++;
      end else begin
        check_field("hue", hsv_expect_q[0].hue, hsv.hue);
        check_field("saturation", hsv_expect_q[0].sat, hsv.saturation);
        check_field("brightness", hsv_expect_q[0].bright, hsv.brightness);
        void'(hsv_expect_q.pop_front());
      end
    end
    if (pix_took || hsv_took) stall_cycles = 0;
    else if (rst_n) stall_cycles++;
  end

  // One traffic phase. The previous phase first sends all of its pixels.
  // The sender is then held while the new pixels are queued and until every
  // result of the previous phase has come back, so the pipeline fully drains
  // between phases.
  task automatic run_phase(input int src_pct, input int snk_pct, input int n_rand,
                           input bit with_corners);
    while (pixel_q.size() != 0) @(posedge clk);
    tx_hold = 1'b1;
    if (with_corners) begin
      foreach (CORNER_PIX[i]) pixel_q.push_back(rgb_t'(CORNER_PIX[i]));
    end
    repeat (n_rand) pixel_q.push_back(rand_pixel());
    while (tx_valid || hsv_expect_q.size() != 0) @(posedge clk);
    tx_idle_pct = src_pct;
    rx_idle_pct = snk_pct;
    tx_hold     = 1'b0;
  endtask

  // Hang detector.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    run_phase(32, 50, 330, 1'b1); // sender idles less than receiver
    run_phase(50, 32, 350, 1'b0); // roles swapped
    run_phase(0, 0, 350, 1'b0);   // full rate both ways

    while (pixel_q.size() != 0 || tx_valid || hsv_expect_q.size() != 0) @(posedge clk);
    // Catch any stray result that trails the last expected one.
    repeat (2 * LATENCY) @(posedge clk);
    if (hsv_expect_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, hsv_expect_q.size());
      err_cnt++;
    end

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
